>>> rtl/trp_pkg.sv
// Shared types and constants of the telnet receive parser.
// Used by every module of the block; depends on nothing else.
package trp_pkg;

   // Payload store size and the widths that follow from it.
   localparam int PAYLOAD_DEPTH = 64;
   localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);

   // Command queue between the front and the back.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

   // Telnet command bytes.
   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_SE   = 8'd240;

   typedef enum logic [2:0] {
      EV_DATA        = 3'd0,
      EV_WILL        = 3'd1,
      EV_WONT        = 3'd2,
      EV_DO          = 3'd3,
      EV_DONT        = 3'd4,
      EV_SUBNEG_BYTE = 3'd5,
      EV_SUBNEG_NONE = 3'd6
   } event_kind_type;

   typedef enum logic [2:0] {
      PS_DATA,
      PS_IAC,
      PS_WILL,
      PS_WONT,
      PS_DO,
      PS_DONT,
      PS_SUB,
      PS_SUBIAC
   } parse_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      CMD_EMIT,
      CMD_STORE,
      CMD_DRAIN
   } cmd_op_type;

   // One command from the front to the back.
   typedef struct packed {
      cmd_op_type          op;
      event_kind_type      kind;
      logic [7:0]          data;
      logic [CNT_W-1:0]    count;
      logic                trunc;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // One result as held in the output register.
   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     value;
      logic           last;
      logic           trunc;
   } rsp_type;

endpackage

>>> rtl/trp_front.sv
// Front of the telnet receive parser: accepts bytes, tracks the IAC state
// and issues commands to the back. Depends on trp_pkg.
module trp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   output logic                 cmd_push,
   output trp_pkg::cmd_type     cmd_data
);

   trp_pkg::parse_state_type      state_ff, state_in;
   logic [trp_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic                          do_store;

   // State, payload count and overflow flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trp_pkg::PS_DATA;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Classify the accepted byte and build at most one command.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      do_store      = 1'b0;
      cmd_push      = 1'b0;
      cmd_data.op    = trp_pkg::CMD_EMIT;
      cmd_data.kind  = trp_pkg::EV_DATA;
      cmd_data.data  = rx_byte;
      cmd_data.count = count_ff;
      cmd_data.trunc = 1'b0;
      if (accept) begin
         case (state_ff)
            trp_pkg::PS_DATA: begin
               if (rx_byte == trp_pkg::B_IAC) begin
                  state_in = trp_pkg::PS_IAC;
               end else begin
                  cmd_push = 1'b1;
               end
            end
            trp_pkg::PS_IAC: begin
               state_in = trp_pkg::PS_DATA;
               case (rx_byte)
                  trp_pkg::B_IAC:  cmd_push = 1'b1;
                  trp_pkg::B_WILL: state_in = trp_pkg::PS_WILL;
                  trp_pkg::B_WONT: state_in = trp_pkg::PS_WONT;
                  trp_pkg::B_DO:   state_in = trp_pkg::PS_DO;
                  trp_pkg::B_DONT: state_in = trp_pkg::PS_DONT;
                  trp_pkg::B_SB: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                     state_in = trp_pkg::PS_SUB;
                  end
                  default: state_in = trp_pkg::PS_DATA;
               endcase
            end
            trp_pkg::PS_WILL: begin
               cmd_push      = 1'b1;
               cmd_data.kind = trp_pkg::EV_WILL;
               state_in      = trp_pkg::PS_DATA;
            end
            trp_pkg::PS_WONT: begin
               cmd_push      = 1'b1;
               cmd_data.kind = trp_pkg::EV_WONT;
               state_in      = trp_pkg::PS_DATA;
            end
            trp_pkg::PS_DO: begin
               cmd_push      = 1'b1;
               cmd_data.kind = trp_pkg::EV_DO;
               state_in      = trp_pkg::PS_DATA;
            end
            trp_pkg::PS_DONT: begin
               cmd_push      = 1'b1;
               cmd_data.kind = trp_pkg::EV_DONT;
               state_in      = trp_pkg::PS_DATA;
            end
            trp_pkg::PS_SUB: begin
               if (rx_byte == trp_pkg::B_IAC) begin
                  state_in = trp_pkg::PS_SUBIAC;
               end else begin
                  do_store = 1'b1;
               end
            end
            default: begin
               // Inside a payload after IAC: SE closes it, anything else is stored.
               if (rx_byte == trp_pkg::B_SE) begin
                  cmd_push       = 1'b1;
                  cmd_data.trunc = ovf_ff;
                  if (count_ff == '0) begin
                     cmd_data.kind = trp_pkg::EV_SUBNEG_NONE;
                     cmd_data.data = 8'd0;
                  end else begin
                     cmd_data.op = trp_pkg::CMD_DRAIN;
                  end
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = trp_pkg::PS_DATA;
               end else begin
                  do_store = 1'b1;
                  state_in = trp_pkg::PS_SUB;
               end
            end
         endcase

         // Store a payload byte while there is room, otherwise flag the loss.
         if (do_store) begin
            if (count_ff < trp_pkg::CNT_W'(trp_pkg::PAYLOAD_DEPTH)) begin
               cmd_push    = 1'b1;
               cmd_data.op = trp_pkg::CMD_STORE;
               count_in    = count_ff + trp_pkg::CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

endmodule

>>> rtl/trp_cmd_fifo.sv
// Short command queue between the front and the back of the parser.
// Depends on trp_pkg for the command type and the queue depth.
module trp_cmd_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  trp_pkg::cmd_type         push_data,
   input  logic                     pop,
   output trp_pkg::cmd_type         pop_data,
   output trp_pkg::fifo_status_type status
);

   trp_pkg::cmd_type                entries_ff [trp_pkg::FIFO_DEPTH];
   logic [trp_pkg::FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [trp_pkg::FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [trp_pkg::FIFO_CW-1:0]     fill_ff, fill_in;
   logic                            do_push, do_pop;

   // Status and handshake qualification.
   always_comb begin
      status.full  = (fill_ff == trp_pkg::FIFO_CW'(trp_pkg::FIFO_DEPTH));
      status.empty = (fill_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + trp_pkg::FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + trp_pkg::FIFO_AW'(1) : rd_ptr_ff;
      fill_in      = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + trp_pkg::FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - trp_pkg::FIFO_CW'(1);
      end
      pop_data = entries_ff[rd_ptr_ff];
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/trp_back.sv
// Back of the parser: carries out queued commands, owns the payload store
// and the output register. Depends on trp_pkg.
module trp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  trp_pkg::cmd_type         cmd_data,
   input  logic                     cmd_empty,
   output logic                     cmd_pop,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output trp_pkg::rsp_type         rsp_data
);

   trp_pkg::back_state_type         state_ff, state_in;
   logic [trp_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [trp_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            trunc_ff, trunc_in;
   logic                            out_valid_ff, out_valid_in;
   trp_pkg::rsp_type                out_ff, out_in;
   logic [7:0]                      mem [trp_pkg::PAYLOAD_DEPTH];
   logic [7:0]                      mem_q_ff;
   logic                            mem_we, mem_re;
   logic                            out_free, out_load, run_last;

   // Command execution and payload drain sequencing.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      trunc_in  = trunc_ff;
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      out_load  = 1'b0;
      out_free  = !out_valid_ff || rsp_pop;
      run_last  = (idx_ff + trp_pkg::CNT_W'(1)) == cnt_ff;
      out_in.kind  = cmd_data.kind;
      out_in.value = cmd_data.data;
      out_in.last  = 1'b1;
      out_in.trunc = cmd_data.trunc;
      case (state_ff)
         trp_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               case (cmd_data.op)
                  trp_pkg::CMD_EMIT: begin
                     if (out_free) begin
                        cmd_pop  = 1'b1;
                        out_load = 1'b1;
                     end
                  end
                  trp_pkg::CMD_STORE: begin
                     cmd_pop = 1'b1;
                     mem_we  = 1'b1;
                  end
                  trp_pkg::CMD_DRAIN: begin
                     cmd_pop  = 1'b1;
                     cnt_in   = cmd_data.count;
                     trunc_in = cmd_data.trunc;
                     idx_in   = '0;
                     state_in = trp_pkg::BK_READ;
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         trp_pkg::BK_READ: begin
            mem_re   = 1'b1;
            state_in = trp_pkg::BK_EMIT;
         end
         trp_pkg::BK_EMIT: begin
            out_in.kind  = trp_pkg::EV_SUBNEG_BYTE;
            out_in.value = mem_q_ff;
            out_in.last  = run_last;
            out_in.trunc = trunc_ff;
            if (out_free) begin
               out_load = 1'b1;
               if (run_last) begin
                  state_in = trp_pkg::BK_IDLE;
               end else begin
                  idx_in   = idx_ff + trp_pkg::CNT_W'(1);
                  state_in = trp_pkg::BK_READ;
               end
            end
         end
         default: state_in = trp_pkg::BK_IDLE;
      endcase
      out_valid_in = out_load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
      rsp_empty    = !out_valid_ff;
      rsp_data     = out_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trp_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Drain bookkeeping and the output payload.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      trunc_ff <= trunc_in;
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   // Payload store with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd_data.count[trp_pkg::ADDR_W-1:0]] <= cmd_data.data;
      end
      if (mem_re) begin
         mem_q_ff <= mem[idx_ff[trp_pkg::ADDR_W-1:0]];
      end
   end

   // A command is only taken while no drain is in progress.
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> state_ff == trp_pkg::BK_IDLE)
      else $error("command taken during a payload drain");

   // The drain index stays inside the run.
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff != trp_pkg::BK_IDLE) |-> idx_ff < cnt_ff)
      else $error("drain index beyond payload count");

   // A blocked payload byte waits in place.
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == trp_pkg::BK_EMIT && !out_free) |=>
         (state_ff == trp_pkg::BK_EMIT && $stable(idx_ff)))
      else $error("payload byte lost while output was blocked");

   // The output register is never overwritten while a result still waits.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |-> !out_load)
      else $error("waiting result overwritten");

endmodule

>>> rtl/telnet_receive_parser_unit.sv
// Top level of the telnet receive parser: front, command queue and back.
// Depends on trp_pkg, trp_front, trp_cmd_fifo and trp_back.
//
// Takes one received telnet byte per request and delivers the decoded data
// bytes, option events and subnegotiation payloads as results. Plain data,
// option bytes and payload bytes are accepted at one per cycle while the
// four-entry command queue has room. A byte that yields a single result
// is held in a queue entry and then in the output register before it reaches
// the result ports, when nothing waits ahead of it in the queue, no drain runs
// and the output register is free. At IAC SE the stored payload of N bytes is
// read back from the payload store, one read and one output load per byte. The
// front keeps accepting bytes until the command queue fills behind the drain.
// Bytes beyond the 64-entry store are dropped and the run is marked truncated.
module telnet_receive_parser_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [2:0] rsp_event_kind,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_last_of_run,
   output logic       rsp_truncated
);

   trp_pkg::fifo_status_type fifo_status;
   trp_pkg::cmd_type         push_cmd;
   trp_pkg::cmd_type         head_cmd;
   trp_pkg::rsp_type         rsp_data;
   logic                     push_valid;
   logic                     head_pop;
   logic                     req_accept;

   // Request handshake.
   assign req_full   = fifo_status.full;
   assign req_accept = req_push && !fifo_status.full;

   trp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .rx_byte  (req_rx_byte),
      .cmd_push (push_valid),
      .cmd_data (push_cmd)
   );

   trp_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_cmd),
      .pop       (head_pop),
      .pop_data  (head_cmd),
      .status    (fifo_status)
   );

   trp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (head_cmd),
      .cmd_empty (fifo_status.empty),
      .cmd_pop   (head_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // Result fields.
   assign rsp_event_kind  = 3'(rsp_data.kind);
   assign rsp_byte_value  = rsp_data.value;
   assign rsp_last_of_run = rsp_data.last;
   assign rsp_truncated   = rsp_data.trunc;

endmodule
